// File: rtl/sle_pkg.sv
// Shared types, widths and codes for the sequential list engine.
`default_nettype none

package sle_pkg;

    // Word width of one list entry and default list depth.
    localparam int LIST_DW    = 32;
    localparam int LIST_DEPTH = 64;

    // Width of positions and counts carried between cells; covers the largest depth.
    localparam int LIST_PW    = 13;

    // Request codes.
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELAT  = 3'd1;
    localparam logic [2:0] REQ_DELVAL = 3'd2;
    localparam logic [2:0] REQ_FIND   = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Cell update operations.
    localparam logic [1:0] CELL_NOP = 2'd0;
    localparam logic [1:0] CELL_INS = 2'd1;
    localparam logic [1:0] CELL_DEL = 2'd2;

    // Probe modes: match on value or select by position.
    localparam logic MODE_MATCH = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef logic [1:0] t_cell_op;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        t_cell_op                   op;
        logic                       mode;
        logic [LIST_PW-1:0]         act_pos;
        logic [LIST_PW-1:0]         hit_pos;
        logic [LIST_PW-1:0]         count;
        logic signed [LIST_DW-1:0]  value;
    } t_cell_ctl;

    // Probe word handed from cell to cell; the last hit along the chain wins.
    typedef struct packed {
        logic                       hit;
        logic [LIST_PW-1:0]         pos;
        logic signed [LIST_DW-1:0]  data;
    } t_probe;

endpackage

`default_nettype wire

// File: rtl/sequential_list_engine_core.sv
// Top level of the sequential list engine: request sequencer and the chain of list cells.
// Insert, delete-at and unused codes finish without a probe sweep; find, delete-value and read-at
// first wait while the probe walks the chain one cell per cycle. Each result is registered in the
// output stage; finishing stalls while the receiver has not yet taken the last result.
// One item is in work at a time: a new item is accepted only once the last one has finished.
// Synchronous active-low reset empties the list; entry contents are left as they were.
`default_nettype none

module sequential_list_engine_core import sle_pkg::*; #(
    parameter int DEPTH = LIST_DEPTH
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [6:0]            i_position,
    input  wire logic signed [31:0]    i_value,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [2:0]                 o_status,
    output logic [6:0]                 o_found_position,
    output logic signed [31:0]         o_read_value,
    output logic [6:0]                 o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                        r_state;
    logic [2:0]                  r_req;
    logic [6:0]                  r_pos;
    logic signed [LIST_DW-1:0]   r_value;
    logic [CW-1:0]               r_scan;
    logic [CW-1:0]               r_count;

    logic                        r_o_valid;
    logic [2:0]                  r_o_status;
    logic [6:0]                  r_o_fpos;
    logic signed [LIST_DW-1:0]   r_o_rval;
    logic [6:0]                  r_o_count;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_finish;
    logic [LIST_PW-1:0]          w_pos;
    logic [LIST_PW-1:0]          w_cnt;

    logic [2:0]                  f_status;
    logic [LIST_PW-1:0]          f_fpos;
    logic signed [LIST_DW-1:0]   f_rval;
    logic [LIST_PW-1:0]          f_cnt;
    t_cell_op                    f_op;
    logic [LIST_PW-1:0]          f_apos;

    t_cell_ctl                   w_ctl;
    logic signed [LIST_DW-1:0]   w_entry [DEPTH];
    t_probe                      w_probe [DEPTH+1];
    t_probe                      w_last;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_finish   = (r_state == S_EXEC) && (r_scan == '0) && w_out_free;
    assign w_pos      = LIST_PW'(r_pos);
    assign w_cnt      = LIST_PW'(r_count);
    assign w_last     = w_probe[DEPTH];

    // Result and list update for the item in work.
    always_comb begin
        f_status = ST_OK;
        f_fpos   = '0;
        f_rval   = '0;
        f_cnt    = w_cnt;
        f_op     = CELL_NOP;
        f_apos   = '0;
        case (r_req)
            REQ_INSERT: begin
                if (w_cnt >= LIST_PW'(DEPTH)) begin
                    f_status = ST_FULL;
                end else if ((w_pos == '0) || (w_pos > w_cnt + LIST_PW'(1))) begin
                    f_status = ST_BADPOS;
                end else begin
                    f_op   = CELL_INS;
                    f_apos = w_pos;
                    f_cnt  = w_cnt + LIST_PW'(1);
                end
            end
            REQ_DELAT: begin
                if (w_cnt == '0) begin
                    f_status = ST_EMPTY;
                end else if ((w_pos == '0) || (w_pos > w_cnt)) begin
                    f_status = ST_BADPOS;
                end else begin
                    f_op   = CELL_DEL;
                    f_apos = w_pos;
                    f_fpos = w_pos;
                    f_cnt  = w_cnt - LIST_PW'(1);
                end
            end
            REQ_DELVAL: begin
                if (w_cnt == '0) begin
                    f_status = ST_EMPTY;
                end else if (!w_last.hit) begin
                    f_status = ST_NOTFOUND;
                end else begin
                    f_op   = CELL_DEL;
                    f_apos = w_last.pos;
                    f_fpos = w_last.pos;
                    f_cnt  = w_cnt - LIST_PW'(1);
                end
            end
            REQ_FIND: begin
                if (!w_last.hit) begin
                    f_status = ST_NOTFOUND;
                end else begin
                    f_fpos = w_last.pos;
                end
            end
            REQ_READ: begin
                if (w_cnt == '0) begin
                    f_status = ST_EMPTY;
                end else if ((w_pos == '0) || (w_pos > w_cnt)) begin
                    f_status = ST_BADPOS;
                end else begin
                    f_rval = w_last.data;
                end
            end
            default: begin
                f_status = ST_OK;
            end
        endcase
    end

    // Control broadcast to the cells; the update applies only in the finishing cycle.
    always_comb begin
        w_ctl.op      = w_finish ? f_op : CELL_NOP;
        w_ctl.mode    = (r_req == REQ_READ) ? MODE_READ : MODE_MATCH;
        w_ctl.act_pos = f_apos;
        w_ctl.hit_pos = w_pos;
        w_ctl.count   = w_cnt;
        w_ctl.value   = r_value;
    end

    // Cell chain; the probe enters empty at the bottom and leaves at the top.
    assign w_probe[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [LIST_DW-1:0] w_prev;
        logic signed [LIST_DW-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end
        sle_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_entry (w_prev),
            .i_next_entry (w_next),
            .i_probe      (w_probe[g]),
            .o_entry      (w_entry[g]),
            .o_probe      (w_probe[g+1])
        );
    end

    // Sequencer control: accept, sweep the probe if needed, then finish into the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_scan    <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // A finishing item refills the output stage as the receiver takes the old result.
            if (w_finish) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        if (i_req_type inside {REQ_DELVAL, REQ_FIND, REQ_READ}) begin
                            r_scan <= CW'(DEPTH);
                        end else begin
                            r_scan <= '0;
                        end
                    end
                end
                S_EXEC: begin
                    if (r_scan != '0) begin
                        r_scan <= r_scan - CW'(1);
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                        r_count <= CW'(f_cnt);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req_type;
            r_pos   <= i_position;
            r_value <= i_value;
        end
        if (w_finish) begin
            r_o_status <= f_status;
            r_o_fpos   <= f_fpos[6:0];
            r_o_rval   <= f_rval;
            r_o_count  <= f_cnt[6:0];
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_fpos;
    assign o_read_value     = r_o_rval;
    assign o_entry_count    = r_o_count;

    // The entry count never exceeds the list depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LIST_PW'(r_count) <= LIST_PW'(DEPTH)))
        else $error("entry count above depth");

    // A probe sweep only runs while an item is in work.
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan != '0) |-> (r_state == S_EXEC))
        else $error("probe sweep outside execution");

    // A successful insert grows the list by exactly one entry.
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && (f_op == CELL_INS)) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    // A delete shrinks the list by exactly one entry.
    a_delete_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && (f_op == CELL_DEL)) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the list");

    // A not-found result never reports a position.
    a_notfound_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NOTFOUND)) |-> (o_found_position == '0))
        else $error("not-found result carries a position");

endmodule

`default_nettype wire

// File: rtl/sle_cell.sv
// One list cell: holds one entry, shifts with its neighbors and forwards the probe word.
`default_nettype none

module sle_cell import sle_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic signed [LIST_DW-1:0] i_prev_entry,
    input  wire logic signed [LIST_DW-1:0] i_next_entry,
    input  wire t_probe                i_probe,
    output logic signed [LIST_DW-1:0]  o_entry,
    output t_probe                     o_probe
);

    localparam logic [LIST_PW-1:0] IDX0 = LIST_PW'(CELL_IDX);
    localparam logic [LIST_PW-1:0] IDX1 = LIST_PW'(CELL_IDX + 1);

    logic signed [LIST_DW-1:0] r_entry;
    logic signed [LIST_DW-1:0] n_entry;
    t_probe                    r_probe;
    t_probe                    n_probe;
    logic                      w_hit;

    // Entry update: insert moves entries at and after the position up, delete moves them down.
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            CELL_INS: begin
                if (IDX1 == i_ctl.act_pos) begin
                    n_entry = i_ctl.value;
                end else if (IDX1 > i_ctl.act_pos) begin
                    n_entry = i_prev_entry;
                end
            end
            CELL_DEL: begin
                if (IDX1 >= i_ctl.act_pos) begin
                    n_entry = i_next_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // A hit here replaces whatever the probe carried from below.
    always_comb begin
        if (i_ctl.mode == MODE_READ) begin
            w_hit = (IDX1 == i_ctl.hit_pos);
        end else begin
            w_hit = (IDX0 < i_ctl.count) && (r_entry == i_ctl.value);
        end
        if (w_hit) begin
            n_probe.hit  = 1'b1;
            n_probe.pos  = IDX1;
            n_probe.data = r_entry;
        end else begin
            n_probe = i_probe;
        end
    end

    // The entry is payload and the probe word clears at reset; the sequencer waits out a full
    // sweep before using the probe.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_entry = r_entry;
    assign o_probe = r_probe;

endmodule

`default_nettype wire
